// ----- rtl/core/lzwc_pkg.sv -----
// Shared constants and types for the LZW .Z stream compressor.
`timescale 1ns / 1ps
`default_nettype none
package lzwc_pkg;

  localparam logic [7:0]  MAGIC_1     = 8'h1F;
  localparam logic [7:0]  MAGIC_2     = 8'h9D;
  localparam logic [15:0] CLEAR_CODE  = 16'd256;
  localparam logic [16:0] FIRST_CODE  = 17'd257;
  localparam logic [4:0]  START_WIDTH = 5'd9;
  localparam logic [16:0] INIT_LIMIT  = 17'd512;
  localparam logic [16:0] NO_LIMIT    = 17'h1FFFF;
  localparam logic [31:0] RATIO_SAT   = 32'h7FFF_FFFF;
  localparam logic [31:0] BIG_TAKEN   = 32'h007F_FFFF;

  localparam logic [1:0]  CFG_MAX_BITS   = 2'd0;
  localparam logic [1:0]  CFG_BLOCK_MODE = 2'd1;
  localparam logic [1:0]  CFG_OMIT_MAGIC = 2'd2;

  localparam int EPOCH_W = 8;

  // Byte request from the sequencer to the output buffer
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       close;
    logic       done;
  } obuf_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/lzwc_div.sv -----
// Restoring 32 by 32 bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, q_r[31]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      q_nxt   = {q_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ----- rtl/core/lzwc_obuf.sv -----
// Output stage: one byte held back so the last byte of a run can be flagged.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_obuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lzwc_pkg::obuf_req_t req,
  output logic                     ready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,  // out_byte
  output logic                     out_tlast,  // last_of_run
  output logic                     out_tuser   // stream_done
);
  import lzwc_pkg::*;

  logic       pend_v_r, pend_v_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_d_r, out_d_nxt;
  logic       out_l_r, out_l_nxt;
  logic       out_u_r, out_u_nxt;
  logic       out_free;

  assign out_free = !out_v_r || out_tready;
  assign ready    = !pend_v_r || out_free;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_d_nxt  = out_d_r;
    out_l_nxt  = out_l_r;
    out_u_nxt  = out_u_r;
    if (req.emit && ready) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pend_r;
        out_l_nxt = 1'b0;
        out_u_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = req.data;
    end else if (req.close && ready) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pend_r;
        out_l_nxt = 1'b1;
        out_u_nxt = req.done;
      end
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    out_d_r <= out_d_nxt;
    out_l_r <= out_l_nxt;
    out_u_r <= out_u_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_u_r;

endmodule
`default_nettype wire

// ----- rtl/core/lzw_compress_stream_unit.sv -----
// Top level: LZW .Z compressor sequencer around the hashed dictionary memory.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata = data_byte, tlast = end_of_data
//  out_    | out | out_tvalid/tready  | tdata = out_byte, tlast = last_of_run,
//          |     |                    | tuser = stream_done
//  cfg_    | in  | cfg_we             | cfg_addr = register, cfg_wdata = value
//
// A byte runs through S_IDLE, S_PRE, S_RCHK (skipped when the prefix is already a
// dictionary code), S_HASH, S_PRD, S_PCHK, S_TAKEN and S_DONE; each further probe
// repeats S_PRD and S_PCHK, as the dictionary memory read is registered. A miss
// adds S_MISS, S_DRAIN per output byte and S_INS; a ratio check waits in S_RDIV
// for the serial divider. After reset the whole dictionary memory is swept with
// in_tready low, and again once every 255 dictionary clears or stream ends.
// A stalled output holds the sequencer only while a byte is already held back.
`timescale 1ns / 1ps
`default_nettype none
module lzw_compress_stream_unit #(
  parameter int MAX_CODE_WIDTH  = 16,
  parameter int HASH_ENTRIES    = 131072,
  parameter int RATIO_CHECK_GAP = 10000
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte
  input  wire logic       in_tlast,   // end_of_data
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_byte
  output logic            out_tlast,  // last_of_run
  output logic            out_tuser,  // stream_done
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [4:0] cfg_wdata
);
  import lzwc_pkg::*;

  localparam int MW     = MAX_CODE_WIDTH;
  localparam int HAW    = $clog2(HASH_ENTRIES);
  localparam int KEY_W  = MW + 8;
  localparam int WORD_W = EPOCH_W + KEY_W + MW;
  localparam int RSTEPS = ((1 << MW) > HASH_ENTRIES) ?
                          $clog2(((1 << MW) + HASH_ENTRIES - 1) / HASH_ENTRIES) : 0;

  localparam logic [4:0] S_SWEEP = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_HDR   = 5'd2;
  localparam logic [4:0] S_PRE   = 5'd3;
  localparam logic [4:0] S_PAD   = 5'd4;
  localparam logic [4:0] S_RCHK  = 5'd5;
  localparam logic [4:0] S_RDIV  = 5'd6;
  localparam logic [4:0] S_RCMP  = 5'd7;
  localparam logic [4:0] S_CLR   = 5'd8;
  localparam logic [4:0] S_HASH  = 5'd9;
  localparam logic [4:0] S_PRD   = 5'd10;
  localparam logic [4:0] S_PCHK  = 5'd11;
  localparam logic [4:0] S_MISS  = 5'd12;
  localparam logic [4:0] S_INS   = 5'd13;
  localparam logic [4:0] S_TAKEN = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;
  localparam logic [4:0] S_FLUSH = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;
  localparam logic [4:0] S_DRAIN = 5'd18;

  function automatic logic [HAW-1:0] hash_mod(input logic [MW-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int s = RSTEPS - 1; s >= 0; s--) begin
      if (r >= (32'(HASH_ENTRIES) << s)) r = r - (32'(HASH_ENTRIES) << s);
    end
    return r[HAW-1:0];
  endfunction

  // configuration
  logic [4:0] mcb_r;
  logic       bm_r, om_r;

  // sequencer and coder state
  logic [4:0]       state_r, state_nxt, ret_r, ret_nxt, sweep_ret_r, sweep_ret_nxt;
  logic [HAW-1:0]   sweep_addr_r, sweep_addr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic             in_stream_r, in_stream_nxt;
  logic [4:0]       top_w_r, top_w_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [1:0]       hdr_idx_r, hdr_idx_nxt;
  logic [7:0]       c_r, c_nxt;
  logic             last_r, last_nxt;
  logic [MW-1:0]    prefix_r, prefix_nxt;
  logic [16:0]      nfc_r, nfc_nxt, wl_r, wl_nxt;
  logic [4:0]       cw_r, cw_nxt;
  logic             ins_r, ins_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [6:0]       gbo_r, gbo_nxt;
  logic [31:0]      bt_r, bt_nxt, bg_r, bg_nxt, nca_r, nca_nxt, lr_r, lr_nxt;
  logic [31:0]      rat_r, rat_nxt;
  logic             pad_clr_r, pad_clr_nxt;
  logic [HAW-1:0]   probe_r, probe_nxt, disp_r, disp_nxt, tries_r, tries_nxt;
  logic [HAW-1:0]   slot_r, slot_nxt;
  logic             slot_ok_r, slot_ok_nxt;

  // dictionary memory
  logic [WORD_W-1:0] mem [HASH_ENTRIES];
  logic [WORD_W-1:0] mem_rdata_r, mem_wdata;
  logic              mem_we, mem_re;
  logic [HAW-1:0]    mem_waddr;

  // bit packer
  logic [15:0] put_val, put_mask;
  logic [4:0]  put_n, pad_k;
  logic [23:0] put_acc;
  logic [4:0]  put_cnt;
  logic [7:0]  grp_bits, pad_left, gbo_sum;
  logic [6:0]  put_gbo;

  // misc
  obuf_req_t      req;
  logic           obuf_rdy;
  logic           div_start, div_done;
  logic [31:0]    div_num, div_den, div_quot;
  logic [KEY_W-1:0] key;
  logic [MW-1:0]  hv;
  logic [HAW-1:0] hp, dv;
  logic [HAW:0]   wrap_probe;
  logic [4:0]     cw_up, m_clamp;
  logic [31:0]    bg_sh;

  assign key        = {prefix_r, c_r};
  assign hv         = (MW'(c_r) << (MW - 8)) ^ prefix_r;
  assign hp         = hash_mod(hv);
  assign dv         = HAW'(HASH_ENTRIES - 1) - hp;
  assign wrap_probe = (HAW+1)'(probe_r) + (HAW+1)'(HASH_ENTRIES) - (HAW+1)'(disp_r);
  assign cw_up      = cw_r + 5'd1;
  assign bg_sh      = bg_r >> 8;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    m_clamp = mcb_r;
    if (mcb_r < START_WIDTH) m_clamp = START_WIDTH;
    if (mcb_r > 5'(MW))      m_clamp = 5'(MW);
  end

  // put_bits operand by state
  assign grp_bits = {cw_r, 3'b000};
  assign pad_left = grp_bits - {1'b0, gbo_r};
  assign pad_k    = (pad_left > 8'd16) ? 5'd16 : pad_left[4:0];

  always_comb begin
    put_val = '0;
    put_n   = '0;
    unique case (state_r)
      S_CLR: begin
        put_val = CLEAR_CODE;
        put_n   = cw_r;
      end
      S_PAD: begin
        put_n   = pad_k;
      end
      S_MISS, S_FIN: begin
        put_val = 16'(prefix_r);
        put_n   = cw_r;
      end
      default: begin
      end
    endcase
  end

  assign put_mask = 16'((17'd1 << put_n) - 17'd1);
  assign put_acc  = acc_r | (24'(put_val & put_mask) << cnt_r);
  assign put_cnt  = cnt_r + put_n;
  assign gbo_sum  = {1'b0, gbo_r} + 8'(put_n);
  assign put_gbo  = (gbo_sum >= grp_bits) ? 7'(gbo_sum - grp_bits) : gbo_sum[6:0];

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    sweep_ret_nxt  = sweep_ret_r;
    sweep_addr_nxt = sweep_addr_r;
    epoch_nxt      = epoch_r;
    in_stream_nxt  = in_stream_r;
    top_w_nxt      = top_w_r;
    flags_nxt      = flags_r;
    hdr_idx_nxt    = hdr_idx_r;
    c_nxt          = c_r;
    last_nxt       = last_r;
    prefix_nxt     = prefix_r;
    nfc_nxt        = nfc_r;
    cw_nxt         = cw_r;
    wl_nxt         = wl_r;
    ins_nxt        = ins_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    gbo_nxt        = gbo_r;
    bt_nxt         = bt_r;
    bg_nxt         = bg_r;
    nca_nxt        = nca_r;
    lr_nxt         = lr_r;
    rat_nxt        = rat_r;
    pad_clr_nxt    = pad_clr_r;
    probe_nxt      = probe_r;
    disp_nxt       = disp_r;
    tries_nxt      = tries_r;
    slot_nxt       = slot_r;
    slot_ok_nxt    = slot_ok_r;
    req            = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = sweep_addr_r;
    mem_wdata      = '0;

    unique case (state_r)
      S_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr_r == HAW'(HASH_ENTRIES - 1)) begin
          epoch_nxt = EPOCH_W'(1);
          state_nxt = sweep_ret_r;
        end else begin
          sweep_addr_nxt = sweep_addr_r + HAW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          c_nxt    = in_tdata;
          last_nxt = in_tlast;
          if (!in_stream_r) begin
            top_w_nxt   = m_clamp;
            flags_nxt   = {bm_r, 2'b00, m_clamp};
            hdr_idx_nxt = om_r ? 2'd2 : 2'd0;
            state_nxt   = S_HDR;
          end else begin
            state_nxt = S_PRE;
          end
        end
      end
      S_HDR: begin
        req.emit = obuf_rdy;
        case (hdr_idx_r)
          2'd0:    req.data = MAGIC_1;
          2'd1:    req.data = MAGIC_2;
          default: req.data = flags_r;
        endcase
        if (obuf_rdy) begin
          hdr_idx_nxt = hdr_idx_r + 2'd1;
          if (hdr_idx_r == 2'd2) begin
            prefix_nxt    = MW'(c_r);
            bt_nxt        = 32'd1;
            in_stream_nxt = 1'b1;
            state_nxt     = last_r ? S_FIN : S_DONE;
          end
        end
      end
      S_PRE: begin
        priority if (17'(prefix_r) >= FIRST_CODE) begin
          state_nxt = S_HASH;
        end else if (nfc_r >= wl_r) begin
          if (cw_r < top_w_r) begin
            pad_clr_nxt = 1'b0;
            state_nxt   = S_PAD;
          end else begin
            wl_nxt    = NO_LIMIT;
            ins_nxt   = 1'b0;
            state_nxt = S_RCHK;
          end
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_PAD: begin
        if (gbo_r != 7'd0) begin
          acc_nxt   = put_acc;
          cnt_nxt   = put_cnt;
          gbo_nxt   = put_gbo;
          ret_nxt   = S_PAD;
          state_nxt = S_DRAIN;
        end else if (pad_clr_r) begin
          cw_nxt      = START_WIDTH;
          wl_nxt      = INIT_LIMIT;
          nfc_nxt     = FIRST_CODE;
          ins_nxt     = 1'b1;
          pad_clr_nxt = 1'b0;
          state_nxt   = S_HASH;
        end else begin
          cw_nxt    = cw_up;
          wl_nxt    = (cw_up < top_w_r) ? (17'd1 << cw_up) : ((17'd1 << cw_up) - 17'd1);
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!ins_r && bt_r >= nca_r) begin
          nca_nxt = bt_r + 32'(RATIO_CHECK_GAP);
          priority if (bt_r > BIG_TAKEN) begin
            if (bg_sh == 32'd0) begin
              rat_nxt   = RATIO_SAT;
              state_nxt = S_RCMP;
            end else begin
              div_start = 1'b1;
              div_num   = bt_r;
              div_den   = bg_sh;
              state_nxt = S_RDIV;
            end
          end else if (bg_r == 32'd0) begin
            rat_nxt   = RATIO_SAT;
            state_nxt = S_RCMP;
          end else begin
            div_start = 1'b1;
            div_num   = bt_r << 8;
            div_den   = bg_r;
            state_nxt = S_RDIV;
          end
        end else begin
          state_nxt = S_HASH;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          rat_nxt   = div_quot[31] ? RATIO_SAT : div_quot;
          state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        if (rat_r >= lr_r) begin
          lr_nxt    = rat_r;
          state_nxt = S_HASH;
        end else begin
          lr_nxt = '0;
          if (&epoch_r) begin
            sweep_addr_nxt = '0;
            sweep_ret_nxt  = S_CLR;
            state_nxt      = S_SWEEP;
          end else begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        acc_nxt     = put_acc;
        cnt_nxt     = put_cnt;
        gbo_nxt     = put_gbo;
        pad_clr_nxt = 1'b1;
        ret_nxt     = S_PAD;
        state_nxt   = S_DRAIN;
      end
      S_HASH: begin
        probe_nxt = hp;
        disp_nxt  = (dv == '0) ? HAW'(1) : dv;
        tries_nxt = '0;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        mem_re    = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        priority if (mem_rdata_r[WORD_W-1 -: EPOCH_W] != epoch_r) begin
          slot_nxt    = probe_r;
          slot_ok_nxt = 1'b1;
          state_nxt   = S_MISS;
        end else if (mem_rdata_r[MW +: KEY_W] == key) begin
          prefix_nxt = mem_rdata_r[MW-1:0];
          state_nxt  = S_TAKEN;
        end else if (tries_r == HAW'(HASH_ENTRIES - 1)) begin
          slot_ok_nxt = 1'b0;
          state_nxt   = S_MISS;
        end else begin
          probe_nxt = (probe_r >= disp_r) ? (probe_r - disp_r) : wrap_probe[HAW-1:0];
          tries_nxt = tries_r + HAW'(1);
          state_nxt = S_PRD;
        end
      end
      S_MISS: begin
        acc_nxt   = put_acc;
        cnt_nxt   = put_cnt;
        gbo_nxt   = put_gbo;
        ret_nxt   = S_INS;
        state_nxt = S_DRAIN;
      end
      S_INS: begin
        if (ins_r) begin
          if (slot_ok_r) begin
            mem_we    = 1'b1;
            mem_waddr = slot_r;
            mem_wdata = {epoch_r, key, nfc_r[MW-1:0]};
          end
          nfc_nxt = nfc_r + 17'd1;
        end
        prefix_nxt = MW'(c_r);
        state_nxt  = S_TAKEN;
      end
      S_TAKEN: begin
        bt_nxt    = bt_r + 32'd1;
        state_nxt = last_r ? S_FIN : S_DONE;
      end
      S_FIN: begin
        acc_nxt   = put_acc;
        cnt_nxt   = put_cnt;
        gbo_nxt   = put_gbo;
        ret_nxt   = S_FLUSH;
        state_nxt = S_DRAIN;
      end
      S_FLUSH: begin
        if (cnt_r != 5'd0) begin
          req.emit = obuf_rdy;
          req.data = acc_r[7:0];
          if (obuf_rdy) begin
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        req.close = 1'b1;
        req.done  = last_r;
        if (obuf_rdy) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            prefix_nxt    = '0;
            nfc_nxt       = FIRST_CODE;
            cw_nxt        = START_WIDTH;
            wl_nxt        = INIT_LIMIT;
            ins_nxt       = 1'b1;
            acc_nxt       = '0;
            cnt_nxt       = '0;
            gbo_nxt       = '0;
            bt_nxt        = '0;
            bg_nxt        = '0;
            nca_nxt       = 32'(RATIO_CHECK_GAP);
            lr_nxt        = '0;
            in_stream_nxt = 1'b0;
            top_w_nxt     = 5'(MW);
            if (&epoch_r) begin
              sweep_addr_nxt = '0;
              sweep_ret_nxt  = S_IDLE;
              state_nxt      = S_SWEEP;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (cnt_r >= 5'd8) begin
          req.emit = obuf_rdy;
          req.data = acc_r[7:0];
          if (obuf_rdy) begin
            acc_nxt = acc_r >> 8;
            cnt_nxt = cnt_r - 5'd8;
          end
        end else begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (req.emit) bg_nxt = bg_nxt + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcb_r <= 5'd16;
      bm_r  <= 1'b1;
      om_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_BITS:   mcb_r <= cfg_wdata;
        CFG_BLOCK_MODE: bm_r  <= cfg_wdata[0];
        CFG_OMIT_MAGIC: om_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      ret_r        <= S_IDLE;
      sweep_ret_r  <= S_IDLE;
      sweep_addr_r <= '0;
      epoch_r      <= EPOCH_W'(1);
      in_stream_r  <= 1'b0;
      top_w_r      <= 5'(MW);
      prefix_r     <= '0;
      nfc_r        <= FIRST_CODE;
      cw_r         <= START_WIDTH;
      wl_r         <= INIT_LIMIT;
      ins_r        <= 1'b1;
      acc_r        <= '0;
      cnt_r        <= '0;
      gbo_r        <= '0;
      bt_r         <= '0;
      bg_r         <= '0;
      nca_r        <= 32'(RATIO_CHECK_GAP);
      lr_r         <= '0;
      pad_clr_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      sweep_ret_r  <= sweep_ret_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      epoch_r      <= epoch_nxt;
      in_stream_r  <= in_stream_nxt;
      top_w_r      <= top_w_nxt;
      prefix_r     <= prefix_nxt;
      nfc_r        <= nfc_nxt;
      cw_r         <= cw_nxt;
      wl_r         <= wl_nxt;
      ins_r        <= ins_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      gbo_r        <= gbo_nxt;
      bt_r         <= bt_nxt;
      bg_r         <= bg_nxt;
      nca_r        <= nca_nxt;
      lr_r         <= lr_nxt;
      pad_clr_r    <= pad_clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r   <= flags_nxt;
    hdr_idx_r <= hdr_idx_nxt;
    c_r       <= c_nxt;
    last_r    <= last_nxt;
    rat_r     <= rat_nxt;
    probe_r   <= probe_nxt;
    disp_r    <= disp_nxt;
    tries_r   <= tries_nxt;
    slot_r    <= slot_nxt;
    slot_ok_r <= slot_ok_nxt;
  end

  // entries stamped with an older epoch read as empty
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata_r <= mem[probe_r];
  end

  lzwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  lzwc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .ready      (obuf_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- rtl/core/lzwc_checker.sv -----
// Port-level checks for the compressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("stream end not on last byte of a run");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during dictionary sweep");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input taken before first was processed");

endmodule

bind lzw_compress_stream_unit lzwc_checker u_lzwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
